/* hw/rtl/euler_rotate_3d_macros.svh */
// Assertion macros for the euler_rotate_3d RTL; er3d_angle is the module that uses them.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef EULER_ROTATE_3D_MACROS_SVH
`define EULER_ROTATE_3D_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ER3D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("er3d assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ER3D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("er3d assertion failed");

`endif

/* hw/rtl/er3d_pkg.sv */
// Package for the euler_rotate_3d block: widths, constants, axis codes and
// the CORDIC arctangent table. No dependencies.
package er3d_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CORDIC_ITER_DEF = 20;
  localparam int ANGLE_W         = 17;
  localparam int FULL_TURN       = 46080;
  localparam int ANGLE_LAT       = 6;
  localparam int XY_W            = 33;
  localparam int TRIG_W          = XY_W + 1;
  localparam int Z_W             = 33;
  localparam int GAIN_Q30        = 652032874;
  localparam int RECIP_90_Q22    = 46604;
  localparam longint RECIP_90_Q36 = 763549741;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  function automatic logic signed [Z_W-1:0] er3d_atan(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 33'sh020000000;
      5'd1:  v = 33'sh012E4051E;
      5'd2:  v = 33'sh009FB385B;
      5'd3:  v = 33'sh0051111D4;
      5'd4:  v = 33'sh0028B0D43;
      5'd5:  v = 33'sh00145D7E1;
      5'd6:  v = 33'sh000A2F61E;
      5'd7:  v = 33'sh000517C55;
      5'd8:  v = 33'sh00028BE53;
      5'd9:  v = 33'sh000145F2F;
      5'd10: v = 33'sh0000A2F98;
      5'd11: v = 33'sh0000517CC;
      5'd12: v = 33'sh000028BE6;
      5'd13: v = 33'sh0000145F3;
      5'd14: v = 33'sh000000A2FA;
      5'd15: v = 33'sh00000517D;
      5'd16: v = 33'sh0000028BE;
      5'd17: v = 33'sh00000145F;
      5'd18: v = 33'sh000000A30;
      5'd19: v = 33'sh000000518;
      5'd20: v = 33'sh00000028C;
      5'd21: v = 33'sh000000146;
      5'd22: v = 33'sh0000000A3;
      5'd23: v = 33'sh000000051;
      5'd24: v = 33'sh000000029;
      5'd25: v = 33'sh000000014;
      5'd26: v = 33'sh00000000A;
      5'd27: v = 33'sh000000005;
      5'd28: v = 33'sh000000003;
      5'd29: v = 33'sh000000001;
      5'd30: v = 33'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/euler_rotate_3d.sv */
// Top level of the 3D Euler rotation block: input handshake, angle and CORDIC
// chains, point delay line, three axis rotations and output saturation.
// Depends on er3d_pkg, er3d_angle, er3d_cordic and er3d_rot.
//
// Rotates a signed fixed-point point about X, Y then Z (mode 0) or about Z, Y
// then X by the negated angles (mode 1); angles are in 1/128 degree. The
// block is fully pipelined and takes one transaction per clock cycle while the
// output is not stalled. The pipe is made of the angle-to-phase stages, one
// CORDIC stage per iteration and the sign fix, three stages per axis rotation
// and the output register. A stall on the output side freezes the whole pipe.
module euler_rotate_3d
  import er3d_pkg::*;
#(
  parameter int COORD_WIDTH       = COORD_WIDTH_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // point_x, point_y, point_z, angle_x, angle_y, angle_z, zero pad
  input  logic [((3*COORD_WIDTH+3*ANGLE_W+7)/8)*8-1:0] in_tdata,
  // mode
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // rotated_x, rotated_y, rotated_z, zero pad
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata
);

  localparam int W      = COORD_WIDTH;
  localparam int VW     = W + 3;
  localparam int DL     = ANGLE_LAT + CORDIC_ITERATIONS + 1;
  localparam int OUT_DW = ((3*W+7)/8)*8;
  localparam logic signed [VW-1:0] SAT_HI = VW'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - VW'(1);

  logic en;
  logic accept;

  logic [2:0] av, cv;
  logic signed [2:0][Z_W-1:0]  az;
  logic [2:0]                  aneg;
  logic signed [2:0][XY_W-1:0] cos_w, sin_w;

  logic                      dmode_r [DL];
  logic signed [2:0][VW-1:0] dpt_r   [DL];

  logic                        rv   [4];
  logic                        rm   [4];
  logic signed [2:0][VW-1:0]   rvec [4];
  logic signed [2:0][XY_W-1:0] rcos [4];
  logic signed [2:0][XY_W-1:0] rsin [4];

  logic                out_valid_r;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;
  logic signed [W-1:0] sat [3];

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  for (genvar j = 0; j < 3; j++) begin : g_axis
    logic signed [ANGLE_W-1:0] ang;
    logic signed [17:0]        ang_e;
    assign ang   = in_tdata[3*W + ANGLE_W*j +: ANGLE_W];
    assign ang_e = in_tuser ? -18'(ang) : 18'(ang);

    er3d_angle u_angle (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (accept),
      .in_angle  (ang_e),
      .out_valid (av[j]),
      .out_z     (az[j]),
      .out_neg   (aneg[j])
    );

    er3d_cordic #(
      .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (av[j]),
      .in_z      (az[j]),
      .in_neg    (aneg[j]),
      .out_valid (cv[j]),
      .out_cos   (cos_w[j]),
      .out_sin   (sin_w[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmode_r[0]  <= in_tuser;
      dpt_r[0][0] <= VW'(signed'(in_tdata[W-1:0]));
      dpt_r[0][1] <= VW'(signed'(in_tdata[2*W-1:W]));
      dpt_r[0][2] <= VW'(signed'(in_tdata[3*W-1:2*W]));
      for (int k = 1; k < DL; k++) begin
        dmode_r[k] <= dmode_r[k-1];
        dpt_r[k]   <= dpt_r[k-1];
      end
    end
  end

  assign rv[0]   = &cv;
  assign rm[0]   = dmode_r[DL-1];
  assign rvec[0] = dpt_r[DL-1];
  assign rcos[0] = cos_w;
  assign rsin[0] = sin_w;

  for (genvar p = 0; p < 3; p++) begin : g_rot
    er3d_rot #(
      .POS (p),
      .VW  (VW)
    ) u_rot (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (rv[p]),
      .in_mode   (rm[p]),
      .in_v      (rvec[p]),
      .in_cos    (rcos[p]),
      .in_sin    (rsin[p]),
      .out_valid (rv[p+1]),
      .out_mode  (rm[p+1]),
      .out_v     (rvec[p+1]),
      .out_cos   (rcos[p+1]),
      .out_sin   (rsin[p+1])
    );
  end

  always_comb begin
    out_data_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      if (signed'(rvec[3][k]) > SAT_HI) begin
        sat[k] = SAT_HI[W-1:0];
      end else if (signed'(rvec[3][k]) < SAT_LO) begin
        sat[k] = SAT_LO[W-1:0];
      end else begin
        sat[k] = rvec[3][k][W-1:0];
      end
      out_data_nxt[W*k +: W] = sat[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rv[3] && (rm[3] == rm[3]) && (rcos[3] == rcos[3])
                     && (rsin[3] == rsin[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/er3d_angle.sv */
// Angle front end: reduces an angle modulo one turn, converts it to a binary
// phase and folds it into the CORDIC range. Depends on er3d_pkg and the macros.
`include "euler_rotate_3d_macros.svh"

module er3d_angle
  import er3d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [17:0]    in_angle,
  output logic                  out_valid,
  output logic signed [Z_W-1:0] out_z,
  output logic                  out_neg
);

  localparam logic signed [17:0] TURN_S  = 18'(FULL_TURN);
  localparam logic signed [17:0] TURN2_S = 18'(2 * FULL_TURN);

  logic [5:0] v_r;

  logic [15:0] r1_r, r1_nxt;
  logic [15:0] r2_r;
  logic [8:0]  q2_r, q2_nxt;
  logic [8:0]  q3_r;
  logic [29:0] n3_r, n3_nxt;
  logic [8:0]  q4_r;
  logic [29:0] n4_r;
  logic [22:0] t4_r, t4_nxt;
  logic [31:0] ph5_r, ph5_nxt;
  logic signed [Z_W-1:0] z6_r, z6_nxt;
  logic neg6_r, neg6_nxt;

  logic [31:0] prod_q;
  logic [15:0] m_full;
  logic [59:0] prod_t;
  logic [30:0] rem;
  logic [23:0] t_adj;
  logic signed [31:0] zs;

  always_comb begin
    if (in_angle < 18'sd0) begin
      if (in_angle >= -TURN_S) begin
        r1_nxt = 16'(in_angle + TURN_S);
      end else begin
        r1_nxt = 16'(in_angle + TURN2_S);
      end
    end else if (in_angle >= TURN_S) begin
      r1_nxt = 16'(in_angle - TURN_S);
    end else begin
      r1_nxt = 16'(in_angle);
    end

    prod_q = 32'(r1_r) * 32'(RECIP_90_Q22);
    q2_nxt = prod_q[30:22];

    m_full = r2_r - 16'(q2_r) * 16'd90;
    n3_nxt = {m_full[6:0], 23'd0} + 30'd45;

    prod_t = 60'(n3_r) * 60'(RECIP_90_Q36);
    t4_nxt = prod_t[58:36];

    rem   = 31'(n4_r) - 31'(t4_r) * 31'd90;
    t_adj = (rem >= 31'd90) ? 24'(t4_r) + 24'd1 : 24'(t4_r);
    ph5_nxt = {q4_r, t_adj[22:0]};

    zs = signed'(ph5_r);
    if (zs > 32'sh40000000) begin
      z6_nxt   = Z_W'(zs) - Z_W'(33'sh080000000);
      neg6_nxt = 1'b1;
    end else if (zs < -32'sh40000000) begin
      z6_nxt   = Z_W'(zs) + Z_W'(33'sh080000000);
      neg6_nxt = 1'b1;
    end else begin
      z6_nxt   = Z_W'(zs);
      neg6_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r   <= r1_nxt;
      r2_r   <= r1_r;
      q2_r   <= q2_nxt;
      q3_r   <= q2_r;
      n3_r   <= n3_nxt;
      q4_r   <= q3_r;
      n4_r   <= n3_r;
      t4_r   <= t4_nxt;
      ph5_r  <= ph5_nxt;
      z6_r   <= z6_nxt;
      neg6_r <= neg6_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign out_z     = z6_r;
  assign out_neg   = neg6_r;

  `ER3D_ASSERT_IMPL(a_turn_reduced, v_r[0], r1_r < 16'(FULL_TURN))
  `ER3D_ASSERT_IMPL(a_rem_small, v_r[2], n3_r[29:23] < 7'd90)
  `ER3D_ASSERT_IMPL(a_fold_range, v_r[5], (z6_r <= 33'sh040000000) && (z6_r >= -33'sh040000000))

endmodule

/* hw/rtl/er3d_cordic.sv */
// Pipelined rotation-mode CORDIC: one iteration per register stage, then the
// half-turn sign fix. Gives cosine and sine in Q30. Depends on er3d_pkg.
module er3d_cordic
  import er3d_pkg::*;
#(
  parameter int ITER = CORDIC_ITER_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [Z_W-1:0]  in_z,
  input  logic                   in_neg,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_cos,
  output logic signed [XY_W-1:0] out_sin
);

  logic signed [XY_W-1:0] x_r [ITER];
  logic signed [XY_W-1:0] y_r [ITER];
  logic signed [Z_W-1:0]  z_r [ITER];
  logic                   n_r [ITER];
  logic [ITER-1:0]        v_r;

  logic signed [XY_W-1:0] x_src [ITER];
  logic signed [XY_W-1:0] y_src [ITER];
  logic signed [Z_W-1:0]  z_src [ITER];
  logic                   n_src [ITER];

  logic signed [XY_W-1:0] cos_r, sin_r;
  logic                   vo_r;

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [XY_W-1:0] dx, dy;
    if (i == 0) begin : g_first
      assign x_src[i] = XY_W'(GAIN_Q30);
      assign y_src[i] = '0;
      assign z_src[i] = in_z;
      assign n_src[i] = in_neg;
    end else begin : g_next
      assign x_src[i] = x_r[i-1];
      assign y_src[i] = y_r[i-1];
      assign z_src[i] = z_r[i-1];
      assign n_src[i] = n_r[i-1];
    end

    assign dx = y_src[i] >>> i;
    assign dy = x_src[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_src[i] >= 0) begin
          x_r[i] <= x_src[i] - dx;
          y_r[i] <= y_src[i] + dy;
          z_r[i] <= z_src[i] - er3d_atan(5'(i));
        end else begin
          x_r[i] <= x_src[i] + dx;
          y_r[i] <= y_src[i] - dy;
          z_r[i] <= z_src[i] + er3d_atan(5'(i));
        end
        n_r[i] <= n_src[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[ITER-2:0], in_valid};
      vo_r <= v_r[ITER-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= n_r[ITER-1] ? -x_r[ITER-1] : x_r[ITER-1];
      sin_r <= n_r[ITER-1] ? -y_r[ITER-1] : y_r[ITER-1];
    end
  end

  assign out_valid = vo_r;
  assign out_cos   = cos_r;
  assign out_sin   = sin_r;

endmodule

/* hw/rtl/er3d_rot.sv */
// One axis rotation of the point in three stages: partial products, sums,
// then Q30 rounding. Carries the trig values of all axes. Depends on er3d_pkg.
module er3d_rot
  import er3d_pkg::*;
#(
  parameter int POS = 0,
  parameter int VW  = COORD_WIDTH_DEF + 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic                               in_mode,
  input  logic signed [2:0][VW-1:0]          in_v,
  input  logic signed [2:0][XY_W-1:0]        in_cos,
  input  logic signed [2:0][XY_W-1:0]        in_sin,
  output logic                               out_valid,
  output logic                               out_mode,
  output logic signed [2:0][VW-1:0]          out_v,
  output logic signed [2:0][XY_W-1:0]        out_cos,
  output logic signed [2:0][XY_W-1:0]        out_sin
);

  localparam int AHW = VW - 16;
  localparam int HPW = AHW + TRIG_W;
  localparam int LPW = 17 + TRIG_W;
  localparam int HSW = HPW + 1;
  localparam int LSW = LPW + 1;
  localparam int FW  = HSW + 17;

  axis_t axis;
  logic signed [VW-1:0]     a, b;
  logic signed [TRIG_W-1:0] c, sp;
  logic signed [AHW-1:0]    ah, bh;
  logic signed [16:0]       al, bl;

  logic [2:0] v_r;
  axis_t ax1_r, ax2_r, ax3_r;
  logic  m1_r, m2_r, m3_r;
  logic signed [2:0][VW-1:0]   v1_r, v2_r, v3_r;
  logic signed [2:0][XY_W-1:0] c1_r, c2_r, c3_r, s1_r, s2_r, s3_r;
  logic signed [HPW-1:0] ahc_r, bhs_r, ahs_r, bhc_r;
  logic signed [LPW-1:0] alc_r, bls_r, als_r, blc_r;
  logic signed [HSW-1:0] hia_r, hia_nxt, hib_r, hib_nxt;
  logic signed [LSW-1:0] loa_r, loa_nxt, lob_r, lob_nxt;
  logic signed [FW-1:0]  acc_a, acc_b;
  logic signed [VW-1:0]  ra, rb;
  logic signed [2:0][VW-1:0] v3_nxt;

  always_comb begin
    if (POS == 1) begin
      axis = AXIS_Y;
    end else if (in_mode ^ (POS == 2)) begin
      axis = AXIS_Z;
    end else begin
      axis = AXIS_X;
    end

    unique case (axis)
      AXIS_X: begin
        a  = in_v[1];
        b  = in_v[2];
        c  = TRIG_W'(signed'(in_cos[0]));
        sp = -TRIG_W'(signed'(in_sin[0]));
      end
      AXIS_Y: begin
        a  = in_v[0];
        b  = in_v[2];
        c  = TRIG_W'(signed'(in_cos[1]));
        sp = TRIG_W'(signed'(in_sin[1]));
      end
      AXIS_Z: begin
        a  = in_v[0];
        b  = in_v[1];
        c  = TRIG_W'(signed'(in_cos[2]));
        sp = TRIG_W'(signed'(in_sin[2]));
      end
      default: begin
        a  = '0;
        b  = '0;
        c  = '0;
        sp = '0;
      end
    endcase

    ah = a[VW-1:16];
    bh = b[VW-1:16];
    al = signed'({1'b0, a[15:0]});
    bl = signed'({1'b0, b[15:0]});

    hia_nxt = HSW'(ahc_r) + HSW'(bhs_r);
    loa_nxt = LSW'(alc_r) + LSW'(bls_r);
    hib_nxt = HSW'(bhc_r) - HSW'(ahs_r);
    lob_nxt = LSW'(blc_r) - LSW'(als_r);

    acc_a = (FW'(hia_r) <<< 16) + FW'(loa_r) + (FW'(1) <<< 29);
    acc_b = (FW'(hib_r) <<< 16) + FW'(lob_r) + (FW'(1) <<< 29);
    ra = VW'(acc_a >>> 30);
    rb = VW'(acc_b >>> 30);

    v3_nxt = v2_r;
    case (ax2_r)
      AXIS_X: begin
        v3_nxt[1] = ra;
        v3_nxt[2] = rb;
      end
      AXIS_Y: begin
        v3_nxt[0] = ra;
        v3_nxt[2] = rb;
      end
      default: begin
        v3_nxt[0] = ra;
        v3_nxt[1] = rb;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ahc_r <= HPW'(ah) * HPW'(c);
      bhs_r <= HPW'(bh) * HPW'(sp);
      ahs_r <= HPW'(ah) * HPW'(sp);
      bhc_r <= HPW'(bh) * HPW'(c);
      alc_r <= LPW'(al) * LPW'(c);
      bls_r <= LPW'(bl) * LPW'(sp);
      als_r <= LPW'(al) * LPW'(sp);
      blc_r <= LPW'(bl) * LPW'(c);
      ax1_r <= axis;
      m1_r  <= in_mode;
      v1_r  <= in_v;
      c1_r  <= in_cos;
      s1_r  <= in_sin;

      hia_r <= hia_nxt;
      loa_r <= loa_nxt;
      hib_r <= hib_nxt;
      lob_r <= lob_nxt;
      ax2_r <= ax1_r;
      m2_r  <= m1_r;
      v2_r  <= v1_r;
      c2_r  <= c1_r;
      s2_r  <= s1_r;

      ax3_r <= ax2_r;
      m3_r  <= m2_r;
      v3_r  <= v3_nxt;
      c3_r  <= c2_r;
      s3_r  <= s2_r;
    end
  end

  assign out_valid = v_r[2] && (ax3_r == ax3_r);
  assign out_mode  = m3_r;
  assign out_v     = v3_r;
  assign out_cos   = c3_r;
  assign out_sin   = s3_r;

endmodule

/* tb/tb_euler_rotate_3d.sv */
// Self-checking testbench for euler_rotate_3d: drives random and corner points
// through the stream input and checks each rotated point against a predictor.
// Depends on er3d_pkg and the euler_rotate_3d RTL.
`timescale 1ns / 1ps

module tb_euler_rotate_3d;
  import er3d_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int ITERS = CORDIC_ITER_DEF;
  localparam int IN_W = ((3*CW+3*ANGLE_W+7)/8)*8;
  localparam int OUT_W = ((3*CW+7)/8)*8;
  localparam int LATENCY = 17 + ITERS;
  localparam longint Q30 = 64'sd1073741824;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic mode;
    logic signed [CW-1:0] px, py, pz;
    logic signed [ANGLE_W-1:0] ax, ay, az;
  } point_item_t;

  typedef struct packed {
    logic signed [CW-1:0] rz, ry, rx;
  } rotated_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;

  point_item_t pending_points[$];
  rotated_t expected_points[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit hold_sender = 0;
  bit in_fire = 0;
  int long_hold = 0;
  int send_gap = 0;
  int recv_gap = 0;

  euler_rotate_3d uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int k);
    longint t[32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000};
    return t[k];
  endfunction

  function automatic void trig_of(input longint ang, output longint c, output longint s);
    longint r, ph, z, x, y, dx, dy;
    bit flip;
    r = ang % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    ph = ((r <<< 32) + FULL_TURN / 2) / FULL_TURN;
    z = (ph >= 64'h80000000) ? ph - 64'h100000000 : ph;
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000;
      flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000;
      flip = 1;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = shr_floor(y, i % 32);
      dy = shr_floor(x, i % 32);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i % 32);
      end else begin
        x += dx; y -= dy; z += atan_entry(i % 32);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint mul_round(longint a, longint p, longint b, longint q);
    longint ah, bh, al, bl;
    ah = shr_floor(a, 30);
    bh = shr_floor(b, 30);
    al = a - ah * Q30;
    bl = b - bh * Q30;
    return ah * p + bh * q + shr_floor(al * p + bl * q + Q30 / 2, 30);
  endfunction

  function automatic void turn_axis(input axis_t axis, input longint ang,
                                    inout longint v[3]);
    longint c, s, n0, n1;
    trig_of(ang, c, s);
    case (axis)
      AXIS_X: begin
        n0 = mul_round(v[1], c, v[2], -s);
        n1 = mul_round(v[1], s, v[2], c);
        v[1] = n0; v[2] = n1;
      end
      AXIS_Y: begin
        n0 = mul_round(v[0], c, v[2], s);
        n1 = mul_round(v[0], -s, v[2], c);
        v[0] = n0; v[2] = n1;
      end
      default: begin
        n0 = mul_round(v[0], c, v[1], s);
        n1 = mul_round(v[0], -s, v[1], c);
        v[0] = n0; v[1] = n1;
      end
    endcase
  endfunction

  function automatic rotated_t rotate_point(point_item_t p);
    longint v[3];
    longint hi, lo;
    logic signed [CW-1:0] r[3];
    rotated_t res;
    v[0] = p.px; v[1] = p.py; v[2] = p.pz;
    if (!p.mode) begin
      turn_axis(AXIS_X, p.ax, v);
      turn_axis(AXIS_Y, p.ay, v);
      turn_axis(AXIS_Z, p.az, v);
    end else begin
      turn_axis(AXIS_Z, -longint'(p.az), v);
      turn_axis(AXIS_Y, -longint'(p.ay), v);
      turn_axis(AXIS_X, -longint'(p.ax), v);
    end
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    for (int j = 0; j < 3; j++) begin
      if (v[j] > hi) v[j] = hi;
      if (v[j] < lo) v[j] = lo;
      r[j] = v[j][CW-1:0];
    end
    res.rx = r[0]; res.ry = r[1]; res.rz = r[2];
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      1: return $signed($urandom_range(0, 2000000)) - 1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return ANGLE_W'($urandom);
      1: return ANGLE_W'(11520 * $signed($urandom_range(0, 8)) - 46080);
      default: return ANGLE_W'($signed($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  task automatic add_point(logic m, logic signed [CW-1:0] x, y, z,
                           logic signed [ANGLE_W-1:0] a, b, c);
    point_item_t p;
    p = '{mode: m, px: x, py: y, pz: z, ax: a, ay: b, az: c};
    pending_points.push_back(p);
  endtask

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Driver.
  always @(negedge clk) begin
    point_item_t p;
    if (rst_n) begin
      if (in_fire) begin
        expected_points.push_back(rotate_point(pending_points.pop_front()));
      end
      if (send_gap > 0) send_gap--;
      if (!in_tvalid || in_fire) begin
        if (pending_points.size() > (in_fire ? 0 : 0) && send_gap == 0 && !hold_sender) begin
          p = pending_points[0];
          in_tvalid <= 1;
          in_tdata <= IN_W'({p.az, p.ay, p.ax, p.pz, p.py, p.px});
          in_tuser <= p.mode;
          if ($urandom_range(0, 3) == 0)
            send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
        end else begin
          in_tvalid <= 0;
        end
      end
    end
  end

  // Receiver ready.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      long_hold--;
      out_tready <= 0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      if ($urandom_range(0, 3) == 0)
        recv_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                               : $urandom_range(1, 3);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    rotated_t got, want;
    cycles <= cycles + 1;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3*CW-1:0];
      if (expected_points.size() == 0) begin
        $display("unexpected result transaction at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.rx !== want.rx) report_mismatch("rotated_x", got.rx, want.rx);
        if (got.ry !== want.ry) report_mismatch("rotated_y", got.ry, want.ry);
        if (got.rz !== want.rz) report_mismatch("rotated_z", got.rz, want.rz);
      end
    end
    if (cycles > LIMIT) begin
      $display("[euler_rotate_3d] ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    add_point(0, 0, 0, 0, 0, 0, 0);
    add_point(0, 32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0);
    add_point(0, mx, mx, mx, 0, 0, 0);
    add_point(1, mn, mn, mn, 0, 0, 0);
    add_point(0, mx, mx, mx, 5760, 5760, 5760);
    add_point(1, mn, mx, mn, 5760, 5760, 5760);
    add_point(0, 32'sh10000, 32'sh10000, 32'sh10000, 11520, 0, 0);
    add_point(0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 11520, 0);
    add_point(0, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 11520);
    add_point(1, 32'sh10000, 32'sh10000, 32'sh10000, 11520, 11520, 11520);
    add_point(0, mn, 1, -1, 46080, -46080, 23040);
    add_point(1, mx, -1, 1, -46080, 46080, -23040);
    add_point(0, 32'sh12345, -32'sh54321, 32'sh777, 17'sh0FFFF, 17'sh10000, -1);
    add_point(1, 32'sh12345, -32'sh54321, 32'sh777, 17'sh10000, 17'sh0FFFF, 1);
    add_point(0, -1, -1, -1, 34560, 34560, 34560);
    add_point(1, 1, 1, 1, 17280, -17280, 40000);
    for (int i = 0; i < 200; i++)
      add_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
                rand_angle(), rand_angle(), rand_angle());
    repeat (3) @(posedge clk);
    rst_n <= 1;
    wait (pending_points.size() < 150);
    @(negedge clk);
    long_hold = 300;
    wait (pending_points.size() == 0);
    @(negedge clk);
    hold_sender = 1;
    wait (expected_points.size() == 0 && !in_tvalid);
    for (int i = 0; i < 300; i++)
      add_point($urandom_range(0, 1), rand_coord(), rand_coord(), rand_coord(),
                rand_angle(), rand_angle(), rand_angle());
    @(negedge clk);
    hold_sender = 0;
    wait (pending_points.size() == 0);
    stim_done = 1;
    @(negedge clk);
    wait (expected_points.size() == 0 && !in_tvalid);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("[euler_rotate_3d] OK");
    end else begin
      $display("[euler_rotate_3d] ERROR");
    end
    $finish;
  end

endmodule
